[hdl/epp_pkg.sv]
// Package for the point projection block: constants, beat types and the arctangent table.
`default_nettype none
package epp_pkg;

    localparam int CORDIC_STEPS    = 24;
    localparam int COORD_W         = 32;
    localparam int SUM_W           = COORD_W + 1;
    localparam int PRESCALE_BITS   = 20;
    localparam int DW              = 56;
    localparam int ANG_W           = 32;
    localparam int PIX_W           = 14;
    localparam int STEP_W          = 5;
    localparam int CFG_IDX_W       = 3;
    localparam int GAIN_W          = 30;
    localparam int FRAC_W          = 33;
    localparam int PROD_W          = FRAC_W + PIX_W + 1;
    localparam int LATENCY         = 2 * CORDIC_STEPS + 7;

    localparam logic [GAIN_W-1:0] INV_GAIN  = GAIN_W'(652032874);
    localparam logic [ANG_W-1:0]  HALF_TURN = 32'h8000_0000;
    localparam logic [PIX_W-1:0]  WIDTH_RST  = PIX_W'(5760);
    localparam logic [PIX_W-1:0]  HEIGHT_RST = PIX_W'(2880);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH    = 3'd0,
        REG_HEIGHT   = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_OFFSET_Y = 3'd3,
        REG_OFFSET_Z = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic                    zero;
        logic                    vert;
        logic signed [DW-1:0]    x;
        logic signed [DW-1:0]    y;
        logic [ANG_W-1:0]        ang;
        logic signed [DW-1:0]    aux;
    } t_cbeat;

    function automatic logic [ANG_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [ANG_W-1:0] t;
        case (i)
            5'd0:    t = 32'd536870912;
            5'd1:    t = 32'd316933406;
            5'd2:    t = 32'd167458907;
            5'd3:    t = 32'd85004756;
            5'd4:    t = 32'd42667331;
            5'd5:    t = 32'd21354465;
            5'd6:    t = 32'd10679838;
            5'd7:    t = 32'd5340245;
            5'd8:    t = 32'd2670163;
            5'd9:    t = 32'd1335087;
            5'd10:   t = 32'd667544;
            5'd11:   t = 32'd333772;
            5'd12:   t = 32'd166886;
            5'd13:   t = 32'd83443;
            5'd14:   t = 32'd41722;
            5'd15:   t = 32'd20861;
            5'd16:   t = 32'd10430;
            5'd17:   t = 32'd5215;
            5'd18:   t = 32'd2608;
            5'd19:   t = 32'd1304;
            5'd20:   t = 32'd652;
            5'd21:   t = 32'd326;
            5'd22:   t = 32'd163;
            5'd23:   t = 32'd81;
            5'd24:   t = 32'd41;
            5'd25:   t = 32'd20;
            5'd26:   t = 32'd10;
            5'd27:   t = 32'd5;
            5'd28:   t = 32'd3;
            5'd29:   t = 32'd1;
            5'd30:   t = 32'd1;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

[hdl/epp_cordic_cell.sv]
// One vectoring CORDIC micro-rotation cell with its output register.
`default_nettype none
module epp_cordic_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [epp_pkg::STEP_W-1:0]    i_step,
    input  wire logic                          i_valid,
    input  wire epp_pkg::t_cbeat               i_beat,
    output logic                               o_valid,
    output epp_pkg::t_cbeat                    o_beat
);

    logic            r_valid;
    epp_pkg::t_cbeat r_beat;
    epp_pkg::t_cbeat n_beat;
    logic signed [epp_pkg::DW-1:0] dx;
    logic signed [epp_pkg::DW-1:0] dy;

    always_comb begin
        dx     = i_beat.y >>> i_step;
        dy     = i_beat.x >>> i_step;
        n_beat = i_beat;
        if (!i_beat.y[epp_pkg::DW-1]) begin
            n_beat.x   = i_beat.x + dx;
            n_beat.y   = i_beat.y - dy;
            n_beat.ang = i_beat.ang + epp_pkg::atan_turn(i_step);
        end else begin
            n_beat.x   = i_beat.x - dx;
            n_beat.y   = i_beat.y + dy;
            n_beat.ang = i_beat.ang - epp_pkg::atan_turn(i_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_beat <= n_beat;
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule
`default_nettype wire

[hdl/epp_cordic_chain.sv]
// Row of CORDIC cells, one per iteration, each step fixed by its place in the row.
`default_nettype none
module epp_cordic_chain (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire epp_pkg::t_cbeat   i_beat,
    output logic                   o_valid,
    output epp_pkg::t_cbeat        o_beat
);

    logic            w_valid [0:epp_pkg::CORDIC_STEPS];
    epp_pkg::t_cbeat w_beat  [0:epp_pkg::CORDIC_STEPS];

    assign w_valid[0] = i_valid;
    assign w_beat[0]  = i_beat;

    for (genvar g = 0; g < epp_pkg::CORDIC_STEPS; g++) begin : g_cell
        epp_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (epp_pkg::STEP_W'(g)),
            .i_valid (w_valid[g]),
            .i_beat  (w_beat[g]),
            .o_valid (w_valid[g+1]),
            .o_beat  (w_beat[g+1])
        );
    end

    assign o_valid = w_valid[epp_pkg::CORDIC_STEPS];
    assign o_beat  = w_beat[epp_pkg::CORDIC_STEPS];

endmodule
`default_nettype wire

[hdl/epp_gain.sv]
// Gain correction of the horizontal distance and setup of the elevation pass.
`default_nettype none
module epp_gain (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire epp_pkg::t_cbeat   i_beat,
    output logic                   o_valid,
    output epp_pkg::t_cbeat        o_beat
);

    localparam int HI_W = epp_pkg::DW - 32;

    logic                                  r_valid1;
    logic [HI_W+epp_pkg::GAIN_W-1:0]       r_hi;
    logic [32+epp_pkg::GAIN_W-1:0]         r_lo;
    logic [epp_pkg::ANG_W-1:0]             r_az;
    logic signed [epp_pkg::DW-1:0]         r_z;
    logic                                  r_zero;
    logic                                  r_vert;
    logic                                  r_valid2;
    epp_pkg::t_cbeat                       r_beat;
    epp_pkg::t_cbeat                       n_beat;
    logic [epp_pkg::DW-1:0]                horiz;

    always_comb begin
        horiz = epp_pkg::DW'({r_hi, 2'b00}) + epp_pkg::DW'(r_lo >> epp_pkg::GAIN_W);
        n_beat.zero = r_zero;
        n_beat.vert = r_vert;
        n_beat.x    = r_vert ? '0 : $signed(horiz);
        n_beat.y    = r_z;
        n_beat.ang  = '0;
        n_beat.aux  = epp_pkg::DW'($signed(r_az));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
        r_hi   <= (HI_W+epp_pkg::GAIN_W)'(i_beat.x[epp_pkg::DW-1:32])
                * (HI_W+epp_pkg::GAIN_W)'(epp_pkg::INV_GAIN);
        r_lo   <= (32+epp_pkg::GAIN_W)'(i_beat.x[31:0])
                * (32+epp_pkg::GAIN_W)'(epp_pkg::INV_GAIN);
        r_az   <= i_beat.vert ? '0 : i_beat.ang;
        r_z    <= i_beat.aux;
        r_zero <= i_beat.zero;
        r_vert <= i_beat.vert;
        r_beat <= n_beat;
    end

    assign o_valid = r_valid2;
    assign o_beat  = r_beat;

endmodule
`default_nettype wire

[hdl/epp_pixel_map.sv]
// Maps azimuth and elevation to a wrapped column and a saturated row.
`default_nettype none
module epp_pixel_map (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [epp_pkg::PIX_W-1:0]    i_width,
    input  wire logic [epp_pkg::PIX_W-1:0]    i_height,
    input  wire logic                         i_valid,
    input  wire epp_pkg::t_cbeat              i_beat,
    output logic                              o_strobe,
    output logic [epp_pkg::PIX_W-1:0]         o_pixel_col,
    output logic [epp_pkg::PIX_W-1:0]         o_pixel_row,
    output logic                              o_point_valid
);

    localparam int VW = epp_pkg::ANG_W + 3;
    localparam logic [epp_pkg::FRAC_W-1:0] FULL = {1'b1, {(epp_pkg::FRAC_W-1){1'b0}}};

    logic                              r_valid1;
    logic                              r_valid2;
    logic                              r_valid3;
    logic                              r_zero1;
    logic                              r_zero2;
    logic [epp_pkg::FRAC_W-1:0]        r_u;
    logic [epp_pkg::FRAC_W-1:0]        r_v;
    logic [epp_pkg::PROD_W-1:0]        r_cp;
    logic [epp_pkg::PROD_W-1:0]        r_rp;
    logic [epp_pkg::PIX_W-1:0]         r_col;
    logic [epp_pkg::PIX_W-1:0]         r_row;
    logic                              r_pv;
    logic [epp_pkg::FRAC_W-1:0]        n_u;
    logic [epp_pkg::FRAC_W-1:0]        n_v;
    logic signed [VW-1:0]              v_full;
    logic [epp_pkg::PIX_W-1:0]         n_col;
    logic [epp_pkg::PIX_W-1:0]         n_row;
    logic [epp_pkg::PROD_W-33:0]       col_raw;
    logic [epp_pkg::PROD_W-33:0]       row_raw;

    always_comb begin
        n_u = {1'b0, epp_pkg::HALF_TURN}
            - {i_beat.aux[epp_pkg::ANG_W-1], i_beat.aux[epp_pkg::ANG_W-1:0]};
        v_full = $signed(VW'({1'b0, epp_pkg::HALF_TURN}))
               - $signed({{2{i_beat.ang[epp_pkg::ANG_W-1]}}, i_beat.ang, 1'b0});
        if (v_full[VW-1]) begin
            n_v = '0;
        end else if (v_full > $signed(VW'(FULL))) begin
            n_v = FULL;
        end else begin
            n_v = v_full[epp_pkg::FRAC_W-1:0];
        end

        col_raw = r_cp[epp_pkg::PROD_W-1:32];
        row_raw = r_rp[epp_pkg::PROD_W-1:32];
        if (col_raw >= (epp_pkg::PROD_W-32)'(i_width)) begin
            n_col = '0;
        end else begin
            n_col = col_raw[epp_pkg::PIX_W-1:0];
        end
        if (i_height == '0) begin
            n_row = '0;
        end else if (row_raw >= (epp_pkg::PROD_W-32)'(i_height)) begin
            n_row = i_height - epp_pkg::PIX_W'(1);
        end else begin
            n_row = row_raw[epp_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
            r_valid3 <= r_valid2;
        end
        r_zero1 <= i_beat.zero;
        r_u     <= n_u;
        r_v     <= n_v;
        r_zero2 <= r_zero1;
        r_cp    <= epp_pkg::PROD_W'(r_u) * epp_pkg::PROD_W'(i_width)
                 + epp_pkg::PROD_W'(epp_pkg::HALF_TURN);
        r_rp    <= epp_pkg::PROD_W'(r_v) * epp_pkg::PROD_W'(i_height)
                 + epp_pkg::PROD_W'(epp_pkg::HALF_TURN);
        r_col   <= r_zero2 ? '0 : n_col;
        r_row   <= r_zero2 ? '0 : n_row;
        r_pv    <= !r_zero2;
    end

    assign o_strobe      = r_valid3;
    assign o_pixel_col   = r_col;
    assign o_pixel_row   = r_row;
    assign o_point_valid = r_pv;

endmodule
`default_nettype wire

[hdl/equirect_point_projection.sv]
// Top level: translation, prescale, two CORDIC cell rows and pixel mapping.
//
//   Channel   Direction  Handshake               Payload
//   point     in         start high, busy low    i_point_x, i_point_y, i_point_z
//   result    out        o_result_strobe         o_pixel_col, o_pixel_row, o_point_valid
//   config    in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
// One point is accepted in every cycle while busy is low; its result passes
// through two rows of CORDIC cells, one cell per iteration.
// Reset is synchronous and clears every valid bit and the registers to their defaults.
// busy is high during reset and in the first cycle after it; the result side cannot stall.
`default_nettype none
module equirect_point_projection (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [epp_pkg::COORD_W-1:0] i_point_x,
    input  wire logic signed [epp_pkg::COORD_W-1:0] i_point_y,
    input  wire logic signed [epp_pkg::COORD_W-1:0] i_point_z,
    output logic                                    o_result_strobe,
    output logic [epp_pkg::PIX_W-1:0]               o_pixel_col,
    output logic [epp_pkg::PIX_W-1:0]               o_pixel_row,
    output logic                                    o_point_valid,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [epp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [epp_pkg::COORD_W-1:0]        i_cfg_data
);

    localparam int PAD = epp_pkg::DW - epp_pkg::SUM_W - epp_pkg::PRESCALE_BITS;

    logic                                 r_busy;
    logic [epp_pkg::PIX_W-1:0]            r_width;
    logic [epp_pkg::PIX_W-1:0]            r_height;
    logic signed [epp_pkg::COORD_W-1:0]   r_off_x;
    logic signed [epp_pkg::COORD_W-1:0]   r_off_y;
    logic signed [epp_pkg::COORD_W-1:0]   r_off_z;
    logic                                 r_valid0;
    logic signed [epp_pkg::SUM_W-1:0]     r_x;
    logic signed [epp_pkg::SUM_W-1:0]     r_y;
    logic signed [epp_pkg::SUM_W-1:0]     r_z;
    logic                                 r_valid1;
    epp_pkg::t_cbeat                      r_beat1;
    epp_pkg::t_cbeat                      n_beat1;
    logic signed [epp_pkg::DW-1:0]        sx;
    logic signed [epp_pkg::DW-1:0]        sy;
    logic signed [epp_pkg::DW-1:0]        sz;
    logic                                 accept;
    logic                                 az_valid;
    epp_pkg::t_cbeat                      az_beat;
    logic                                 gn_valid;
    epp_pkg::t_cbeat                      gn_beat;
    logic                                 el_valid;
    epp_pkg::t_cbeat                      el_beat;

    assign accept      = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_width  <= epp_pkg::WIDTH_RST;
            r_height <= epp_pkg::HEIGHT_RST;
            r_off_x  <= '0;
            r_off_y  <= '0;
            r_off_z  <= '0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    epp_pkg::REG_WIDTH:    r_width  <= i_cfg_data[epp_pkg::PIX_W-1:0];
                    epp_pkg::REG_HEIGHT:   r_height <= i_cfg_data[epp_pkg::PIX_W-1:0];
                    epp_pkg::REG_OFFSET_X: r_off_x  <= i_cfg_data;
                    epp_pkg::REG_OFFSET_Y: r_off_y  <= i_cfg_data;
                    epp_pkg::REG_OFFSET_Z: r_off_z  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        sx = {{PAD{r_x[epp_pkg::SUM_W-1]}}, r_x, {epp_pkg::PRESCALE_BITS{1'b0}}};
        sy = {{PAD{r_y[epp_pkg::SUM_W-1]}}, r_y, {epp_pkg::PRESCALE_BITS{1'b0}}};
        sz = {{PAD{r_z[epp_pkg::SUM_W-1]}}, r_z, {epp_pkg::PRESCALE_BITS{1'b0}}};
        n_beat1.vert = (r_x == '0) && (r_y == '0);
        n_beat1.zero = n_beat1.vert && (r_z == '0);
        n_beat1.aux  = sz;
        if (sx[epp_pkg::DW-1]) begin
            n_beat1.x   = -sx;
            n_beat1.y   = -sy;
            n_beat1.ang = epp_pkg::HALF_TURN;
        end else begin
            n_beat1.x   = sx;
            n_beat1.y   = sy;
            n_beat1.ang = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
            r_valid1 <= 1'b0;
        end else begin
            r_valid0 <= accept;
            r_valid1 <= r_valid0;
        end
        r_x     <= epp_pkg::SUM_W'(i_point_x) + epp_pkg::SUM_W'(r_off_x);
        r_y     <= epp_pkg::SUM_W'(i_point_y) + epp_pkg::SUM_W'(r_off_y);
        r_z     <= epp_pkg::SUM_W'(i_point_z) + epp_pkg::SUM_W'(r_off_z);
        r_beat1 <= n_beat1;
    end

    epp_cordic_chain u_az_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_valid1),
        .i_beat  (r_beat1),
        .o_valid (az_valid),
        .o_beat  (az_beat)
    );

    epp_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (az_valid),
        .i_beat  (az_beat),
        .o_valid (gn_valid),
        .o_beat  (gn_beat)
    );

    epp_cordic_chain u_el_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (gn_valid),
        .i_beat  (gn_beat),
        .o_valid (el_valid),
        .o_beat  (el_beat)
    );

    epp_pixel_map u_map (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_width       (r_width),
        .i_height      (r_height),
        .i_valid       (el_valid),
        .i_beat        (el_beat),
        .o_strobe      (o_result_strobe),
        .o_pixel_col   (o_pixel_col),
        .o_pixel_row   (o_pixel_row),
        .o_point_valid (o_point_valid)
    );

endmodule
`default_nettype wire

[hdl/epp_checker.sv]
// Port-level checker for the point projection block and its bind statement.
`default_nettype none
module epp_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        o_result_strobe,
    input wire logic [epp_pkg::PIX_W-1:0]   o_pixel_col,
    input wire logic [epp_pkg::PIX_W-1:0]   o_pixel_row,
    input wire logic                        o_point_valid,
    input wire logic                        o_cfg_ready
);

    // Every accepted beat yields exactly one result after the fixed pipeline depth.
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(epp_pkg::LATENCY) o_result_strobe)
        else $error("accepted beat produced no result");

    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(start && !busy, epp_pkg::LATENCY))
        else $error("result without an accepted beat");

    a_zero_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_point_valid) |-> (o_pixel_col == '0 && o_pixel_row == '0))
        else $error("zero vector result has nonzero coordinates");

    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_cfg_ready && !o_result_strobe))
        else $error("block not held off after reset");

endmodule

bind equirect_point_projection epp_checker u_epp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_pixel_col     (o_pixel_col),
    .o_pixel_row     (o_pixel_row),
    .o_point_valid   (o_point_valid),
    .o_cfg_ready     (o_cfg_ready)
);
`default_nettype wire
